// File: rtl/core/ttg_pkg.sv
// ----------------------------------------------------------------------------
// ttg_pkg
// Shared types and constants of the trapezoidal trajectory generator.
// ----------------------------------------------------------------------------
package ttg_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;

  // Datapath widths, sized for the largest supported fraction width
  localparam int unsigned TIME_W = 62;
  localparam int unsigned DQ_W   = 64;
  localparam int unsigned WIDE_W = 128;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOL    = 3'd4;

  localparam logic [15:0] TOL_RST = 16'd524;

  // cruise time is capped at 2^60
  localparam logic [TIME_W-1:0] TC_CAP = 62'h1000_0000_0000_0000;

  localparam int unsigned MID_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 8;

  localparam int unsigned STEP_W = 8;
  localparam logic [STEP_W-1:0] MUL_STEPS  = 8'd64;
  localparam logic [STEP_W-1:0] DIV_STEPS  = 8'd128;
  localparam logic [STEP_W-1:0] SQRT_STEPS = 8'd64;

  typedef enum logic [1:0] {
    PH_ACCEL  = 2'd0,
    PH_CRUISE = 2'd1,
    PH_DECEL  = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    ST_VV,
    ST_DA,
    ST_DIVA,
    ST_SQRT,
    ST_MAT,
    ST_MATT,
    ST_DIVC,
    ST_FIN,
    ST_READY
  } setup_state_e;

  typedef struct packed {
    phase_e              phase;
    logic [TIME_W-1:0]   tau;
  } item_t;

  typedef struct packed {
    logic              ready;
    logic              neg;
    logic [31:0]       start;
    logic [31:0]       target;
    logic [31:0]       vel;
    logic [31:0]       acc;
    logic [15:0]       tol;
    logic [32:0]       distance;
    logic [DQ_W-1:0]   dist_q;
    logic [TIME_W-1:0] ta;
    logic [TIME_W-1:0] ta_tc;
    logic [TIME_W-1:0] ttot;
    logic [DQ_W-1:0]   da;
    logic [DQ_W-1:0]   dqmda;
  } prof_t;

endpackage

// File: rtl/core/trapezoidal_trajectory_generator.sv
// ----------------------------------------------------------------------------
// trapezoidal_trajectory_generator
// Commanded position of a point-to-point move under a trapezoidal (or
// triangular) velocity profile, sampled at a given tick count.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  input     in         push / full          elapsed_ticks_i
//  result    out        empty / pop          commanded_position_o, phase_o,
//                                            done_res_o
//  config    in         cfg_we_i             cfg_idx_i, cfg_data_i
//
//  One tick count accepted per cycle while full is low; each result passes
//  the input queue, the two two-stage multipliers, a position register and
//  the output queue. After reset and after every register write the profile
//  solver runs serial multiply and divide, plus square root when triangular;
//  full stays high meanwhile.
//  A stalled result side fills the eight-entry output queue, then the
//  two-entry input queue, then full rises.
// ----------------------------------------------------------------------------
module trapezoidal_trajectory_generator #(
  parameter int unsigned FRAC_BITS = ttg_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [31:0]                    elapsed_ticks_i,
  output logic                           empty,
  input  logic                           pop,
  output logic signed [31:0]             commanded_position_o,
  output logic [1:0]                     phase_o,
  output logic                           done_res_o,
  input  logic                           cfg_we_i,
  input  logic [ttg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ttg_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import ttg_pkg::*;

  prof_t prof;
  item_t item;
  logic  item_valid, item_pop;

  ttg_setup #(.FRAC_BITS(FRAC_BITS)) u_setup (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .prof_o     (prof)
  );

  ttg_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .elapsed_ticks_i (elapsed_ticks_i),
    .prof_i          (prof),
    .item_valid_o    (item_valid),
    .item_o          (item),
    .item_pop_i      (item_pop)
  );

  ttg_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .item_valid_i         (item_valid),
    .item_i               (item),
    .item_pop_o           (item_pop),
    .prof_i               (prof),
    .empty                (empty),
    .pop                  (pop),
    .commanded_position_o (commanded_position_o),
    .phase_o              (phase_o),
    .done_res_o           (done_res_o)
  );

endmodule

// File: rtl/core/ttg_mul.sv
// ----------------------------------------------------------------------------
// ttg_mul
// Two-stage unsigned multiplier: 32x32 partial products, then their sum.
// ----------------------------------------------------------------------------
module ttg_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 32
) (
  input  logic            clk_i,
  input  logic [AW-1:0]   a_i,
  input  logic [BW-1:0]   b_i,
  output logic [AW+BW-1:0] p_o
);

  localparam int unsigned NA = (AW + 31) / 32;
  localparam int unsigned NB = (BW + 31) / 32;
  localparam int unsigned SW = 32 * (NA + NB);

  logic [NA*32-1:0]  a_ext;
  logic [NB*32-1:0]  b_ext;
  logic [63:0]       pp_q [NA][NB];
  logic [SW-1:0]     sum;
  logic [AW+BW-1:0]  p_q;

  assign a_ext = (NA*32)'(a_i);
  assign b_ext = (NB*32)'(b_i);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_q[i][j] <= {32'd0, a_ext[32*i +: 32]} * {32'd0, b_ext[32*j +: 32]};
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum = sum + (SW'(pp_q[i][j]) << (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= sum[AW+BW-1:0];
  end

  assign p_o = p_q;

endmodule

// File: rtl/core/ttg_setup.sv
// ----------------------------------------------------------------------------
// ttg_setup
// Configuration registers and profile solver: works out accelerate time,
// cruise time and ramp distance with a serial multiplier, a restoring divider
// and a digit-by-digit square root.
// ----------------------------------------------------------------------------
module ttg_setup #(
  parameter int unsigned FRAC_BITS = ttg_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ttg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ttg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output ttg_pkg::prof_t                prof_o
);

  import ttg_pkg::*;

  logic [31:0] start_q, target_q, vel_cfg_q, acc_cfg_q;
  logic [15:0] tol_q;

  setup_state_e state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d, steps;
  logic last, load;

  // serial multiplier
  logic [WIDE_W-1:0] ma_q, mp_q, vv_q;
  logic [63:0]       mb_q;
  // divider
  logic [WIDE_W-1:0] dn_q, dq_q;
  logic [31:0]       dd_q, dr_q;
  logic [32:0]       div_r2;
  logic              div_ge;
  // square root
  logic [WIDE_W-1:0] sx_q;
  logic [65:0]       sr_q;
  logic [63:0]       rt_q;
  logic [67:0]       sq_r2, sq_trial;
  logic              sq_ge;

  logic              tri_q, tri_w;
  logic [TIME_W-1:0] ta_q, ta_w, tc_w, tc_sel;
  logic [TIME_W-1:0] ta_tc_q, ttot_q;
  logic [DQ_W-1:0]   da_q, dqmda_q, da_w, dist_q_w;
  logic [31:0]       vel_w, acc_w;
  logic [32:0]       diff_w, dist_w;
  logic              neg_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= '0;
      target_q  <= '0;
      vel_cfg_q <= 32'(1) << FRAC_BITS;
      acc_cfg_q <= 32'(1) << FRAC_BITS;
      tol_q     <= TOL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_START:  start_q   <= cfg_data_i;
        REG_TARGET: target_q  <= cfg_data_i;
        REG_CRUISE: vel_cfg_q <= cfg_data_i;
        REG_ACCEL:  acc_cfg_q <= cfg_data_i;
        REG_TOL:    tol_q     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign vel_w    = (vel_cfg_q == '0) ? 32'd1 : vel_cfg_q;
  assign acc_w    = (acc_cfg_q == '0) ? 32'd1 : acc_cfg_q;
  assign diff_w   = {target_q[31], target_q} - {start_q[31], start_q};
  assign neg_w    = diff_w[32];
  assign dist_w   = neg_w ? (33'd0 - diff_w) : diff_w;
  assign dist_q_w = DQ_W'(dist_w) << FRAC_BITS;

  assign tri_w  = vv_q >= (mp_q << FRAC_BITS);
  assign ta_w   = tri_q ? rt_q[TIME_W-1:0] : dq_q[TIME_W-1:0];
  assign da_w   = DQ_W'(mp_q >> (2 * FRAC_BITS + 1));
  assign tc_w   = (dq_q > WIDE_W'(TC_CAP)) ? TC_CAP : dq_q[TIME_W-1:0];
  assign tc_sel = tri_q ? '0 : tc_w;

  assign div_r2 = {dr_q, dn_q[WIDE_W-1]};
  assign div_ge = div_r2 >= {1'b0, dd_q};
  assign sq_r2    = {sr_q, sx_q[WIDE_W-1 -: 2]};
  assign sq_trial = {2'b00, rt_q, 2'b01};
  assign sq_ge    = sq_r2 >= sq_trial;

  // -------- sequencer --------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_VV;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q) inside
      ST_VV, ST_DA, ST_MAT, ST_MATT: steps = MUL_STEPS;
      ST_SQRT:                       steps = SQRT_STEPS;
      ST_DIVA, ST_DIVC:              steps = DIV_STEPS;
      default:                       steps = '0;
    endcase
    last = (cnt_q == steps);
    unique case (state_q)
      ST_VV:    if (last) state_d = ST_DA;
      ST_DA:    if (last) state_d = ST_DIVA;
      ST_DIVA:  if (last) state_d = tri_q ? ST_SQRT : ST_MAT;
      ST_SQRT:  if (last) state_d = ST_MAT;
      ST_MAT:   if (last) state_d = ST_MATT;
      ST_MATT:  if (last) state_d = tri_q ? ST_FIN : ST_DIVC;
      ST_DIVC:  if (last) state_d = ST_FIN;
      ST_FIN:   state_d = ST_READY;
      ST_READY: state_d = ST_READY;
      default:  state_d = ST_VV;
    endcase
    if (cfg_we_i) begin
      state_d = ST_VV;
    end
    if (cfg_we_i || (state_d != state_q) || (state_q == ST_READY)) begin
      cnt_d = '0;
    end else begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  assign load = (cnt_q == '0);

  // -------- arithmetic units --------
  // multiply, divide and square-root states load operands first, then iterate
  always_ff @(posedge clk_i) begin
    unique case (state_q) inside
      ST_VV, ST_DA, ST_MAT, ST_MATT: begin
        if (load) begin
          mp_q <= '0;
          unique case (state_q) inside
            ST_VV: begin
              ma_q <= WIDE_W'(vel_w);
              mb_q <= 64'(vel_w);
            end
            ST_DA: begin
              vv_q <= mp_q;
              ma_q <= WIDE_W'(dist_w);
              mb_q <= 64'(acc_w);
            end
            ST_MAT: begin
              ta_q <= ta_w;
              ma_q <= WIDE_W'(acc_w);
              mb_q <= 64'(ta_w);
            end
            default: begin
              ma_q <= mp_q;
              mb_q <= 64'(ta_q);
            end
          endcase
        end else begin
          if (mb_q[0]) begin
            mp_q <= mp_q + ma_q;
          end
          ma_q <= ma_q << 1;
          mb_q <= mb_q >> 1;
        end
      end
      ST_DIVA, ST_DIVC: begin
        if (load) begin
          dr_q <= '0;
          dq_q <= '0;
          if (state_q == ST_DIVA) begin
            tri_q <= tri_w;
            dd_q  <= acc_w;
            dn_q  <= tri_w ? (WIDE_W'(dist_w) << (3 * FRAC_BITS))
                           : (WIDE_W'(vel_w) << FRAC_BITS);
          end else begin
            dd_q <= vel_w;
            dn_q <= WIDE_W'(dist_q_w - (da_w << 1)) << FRAC_BITS;
          end
        end else begin
          dr_q <= div_ge ? 32'(div_r2 - {1'b0, dd_q}) : div_r2[31:0];
          dq_q <= {dq_q[WIDE_W-2:0], div_ge};
          dn_q <= dn_q << 1;
        end
      end
      ST_SQRT: begin
        if (load) begin
          sx_q <= dq_q;
          sr_q <= '0;
          rt_q <= '0;
        end else begin
          sr_q <= sq_ge ? 66'(sq_r2 - sq_trial) : sq_r2[65:0];
          rt_q <= {rt_q[62:0], sq_ge};
          sx_q <= sx_q << 2;
        end
      end
      ST_FIN: begin
        ta_tc_q <= ta_q + tc_sel;
        ttot_q  <= (ta_q << 1) + tc_sel;
        da_q    <= da_w;
        dqmda_q <= dist_q_w - da_w;
      end
      default: ;
    endcase
  end

  assign prof_o.ready    = (state_q == ST_READY);
  assign prof_o.neg      = neg_w;
  assign prof_o.start    = start_q;
  assign prof_o.target   = target_q;
  assign prof_o.vel      = vel_w;
  assign prof_o.acc      = acc_w;
  assign prof_o.tol      = tol_q;
  assign prof_o.distance = dist_w;
  assign prof_o.dist_q   = dist_q_w;
  assign prof_o.ta       = ta_q;
  assign prof_o.ta_tc    = ta_tc_q;
  assign prof_o.ttot     = ttot_q;
  assign prof_o.da       = da_q;
  assign prof_o.dqmda    = dqmda_q;

  a_cfg_drops_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !prof_o.ready)
    else $error("profile still marked ready after a register write");

  a_fin_then_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && !cfg_we_i) |=> prof_o.ready)
    else $error("solver did not reach ready after its final step");

  a_ready_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prof_o.ready && !cfg_we_i) |=> prof_o.ready)
    else $error("ready dropped without a register write");

endmodule

// File: rtl/core/ttg_front.sv
// ----------------------------------------------------------------------------
// ttg_front
// Takes a tick count, sorts it into a profile phase with the time offset
// that phase needs, and holds it in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ttg_front #(
  parameter int unsigned FRAC_BITS = ttg_pkg::FRAC_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  logic [31:0]    elapsed_ticks_i,
  input  ttg_pkg::prof_t prof_i,
  output logic           item_valid_o,
  output ttg_pkg::item_t item_o,
  input  logic           item_pop_i
);

  import ttg_pkg::*;

  localparam int unsigned PTR_W = $clog2(MID_DEPTH);
  localparam int unsigned CNT_W = $clog2(MID_DEPTH + 1);

  logic [TIME_W-1:0] tq;
  item_t             cls;
  item_t             mem_q [MID_DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              wr_en, q_full;

  assign tq = TIME_W'(elapsed_ticks_i) << FRAC_BITS;

  always_comb begin
    if (tq <= prof_i.ta) begin
      cls.phase = PH_ACCEL;
      cls.tau   = tq;
    end else if (tq <= prof_i.ta_tc) begin
      cls.phase = PH_CRUISE;
      cls.tau   = tq - prof_i.ta;
    end else if (tq <= prof_i.ttot) begin
      cls.phase = PH_DECEL;       // mirrored from the end of the move
      cls.tau   = prof_i.ttot - tq;
    end else begin
      cls.phase = PH_DONE;
      cls.tau   = '0;
    end
  end

  assign q_full = (cnt_q == CNT_W'(MID_DEPTH));
  assign full   = !prof_i.ready || q_full;
  assign wr_en  = push && !full;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) begin
        wr_q <= PTR_W'(wr_q + 1'b1);
      end
      if (item_pop_i) begin
        rd_q <= PTR_W'(rd_q + 1'b1);
      end
      cnt_q <= cnt_q + CNT_W'(wr_en) - CNT_W'(item_pop_i);
    end
  end

  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_q];

endmodule

// File: rtl/core/ttg_back.sv
// ----------------------------------------------------------------------------
// ttg_back
// Evaluates one queued item a cycle as output credit allows: half rate times
// time squared for the ramps, velocity times time for cruise, then clamping,
// direction and the done check. Results wait in an eight-entry output queue.
// ----------------------------------------------------------------------------
module ttg_back #(
  parameter int unsigned FRAC_BITS = ttg_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  ttg_pkg::item_t     item_i,
  output logic               item_pop_o,
  input  ttg_pkg::prof_t     prof_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] commanded_position_o,
  output logic [1:0]         phase_o,
  output logic               done_res_o
);

  import ttg_pkg::*;

  localparam int unsigned M1_W  = 32 + TIME_W;
  localparam int unsigned M2_W  = M1_W + TIME_W;
  localparam int unsigned PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [31:0] pos;
    phase_e      phase;
    logic        done;
  } res_t;

  logic [31:0]       k_sel;
  logic [M1_W-1:0]   m1_p, crv;
  logic [M2_W-1:0]   m2_p;
  logic [DQ_W-1:0]   accv, p_d, cr_d;

  logic              v1_q, v2_q, v3_q, v4_q, v5_q;
  phase_e            ph1_q, ph2_q, ph3_q, ph4_q, ph5_q;
  logic [TIME_W-1:0] tau1_q, tau2_q;
  logic [DQ_W-1:0]   cr3_q, cr4_q, p5_q;

  logic [32:0]       counts, remain;
  logic [33:0]       s34, c34, pos34;
  logic              done_w;
  res_t              res_w;

  res_t              mem_q [OUT_DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]  ocnt_q, infl_q;
  logic              rd_en;

  // credit: everything in flight must find a slot in the output queue
  assign item_pop_o = item_valid_i &&
                      (({1'b0, infl_q} + {1'b0, ocnt_q}) < (CNT_W+1)'(OUT_DEPTH));

  assign k_sel = (item_i.phase == PH_CRUISE) ? prof_i.vel : prof_i.acc;

  ttg_mul #(.AW(32), .BW(TIME_W)) u_mul_k (
    .clk_i (clk_i),
    .a_i   (k_sel),
    .b_i   (item_i.tau),
    .p_o   (m1_p)
  );

  ttg_mul #(.AW(M1_W), .BW(TIME_W)) u_mul_t (
    .clk_i (clk_i),
    .a_i   (m1_p),
    .b_i   (tau2_q),
    .p_o   (m2_p)
  );

  assign crv  = m1_p >> FRAC_BITS;
  assign cr_d = (crv > M1_W'(prof_i.dist_q)) ? prof_i.dist_q : crv[DQ_W-1:0];
  assign accv = DQ_W'(m2_p[WIDE_W-1:0] >> (2 * FRAC_BITS + 1));

  always_comb begin
    case (ph4_q)
      PH_ACCEL:  p_d = (accv > prof_i.dist_q) ? prof_i.dist_q : accv;
      PH_CRUISE: p_d = (cr4_q > prof_i.dqmda) ? prof_i.dist_q : cr4_q + prof_i.da;
      PH_DECEL:  p_d = (accv > prof_i.dist_q) ? '0 : prof_i.dist_q - accv;
      default:   p_d = prof_i.dist_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= item_pop_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ph1_q  <= item_i.phase;
    tau1_q <= item_i.tau;
    ph2_q  <= ph1_q;
    tau2_q <= tau1_q;
    ph3_q  <= ph2_q;
    cr3_q  <= cr_d;
    ph4_q  <= ph3_q;
    cr4_q  <= cr3_q;
    ph5_q  <= ph4_q;
    p5_q   <= p_d;
  end

  // whole counts travelled, then direction and completion
  assign counts = p5_q[FRAC_BITS +: 33];
  assign remain = prof_i.distance - counts;
  assign done_w = (ph5_q == PH_DONE) || (remain < 33'(prof_i.tol));
  assign s34    = {{2{prof_i.start[31]}}, prof_i.start};
  assign c34    = {1'b0, counts};
  assign pos34  = prof_i.neg ? (s34 - c34) : (s34 + c34);

  assign res_w.pos   = done_w ? prof_i.target : pos34[31:0];
  assign res_w.phase = done_w ? PH_DONE : ph5_q;
  assign res_w.done  = done_w;

  assign rd_en = pop && !empty;

  always_ff @(posedge clk_i) begin
    if (v5_q) begin
      mem_q[wr_q] <= res_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      ocnt_q <= '0;
      infl_q <= '0;
    end else begin
      if (v5_q) begin
        wr_q <= PTR_W'(wr_q + 1'b1);
      end
      if (rd_en) begin
        rd_q <= PTR_W'(rd_q + 1'b1);
      end
      ocnt_q <= ocnt_q + CNT_W'(v5_q) - CNT_W'(rd_en);
      infl_q <= infl_q + CNT_W'(item_pop_o) - CNT_W'(v5_q);
    end
  end

  assign empty                = (ocnt_q == '0);
  assign commanded_position_o = mem_q[rd_q].pos;
  assign phase_o              = mem_q[rd_q].phase;
  assign done_res_o           = mem_q[rd_q].done;

  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, infl_q} + {1'b0, ocnt_q}) <= (CNT_W+1)'(OUT_DEPTH))
    else $error("in-flight items exceed output queue space");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q |-> (ocnt_q < CNT_W'(OUT_DEPTH)))
    else $error("result written into a full output queue");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_o |-> ##5 v5_q)
    else $error("popped item did not reach the output stage");

  a_done_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && done_res_o) |-> (phase_o == PH_DONE))
    else $error("done result without complete phase");

endmodule
